@@ sv/cca_pkg.sv @@
// Package: widths, status codes and register indexes of the canonical code assigner.
`timescale 1ns / 1ps

package cca_pkg;

    localparam int CODE_SPACE_BITS = 32;
    localparam int LEN_W           = 8;
    localparam int SYM_W           = 16;
    localparam int LEN_OUT_W       = 7;
    localparam int MAXLEN_W        = 6;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_LENGTH  = 2'd1,
        STATUS_OVERFULL    = 2'd2,
        STATUS_PRIOR_ERROR = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LENGTH    = 2'd0,
        CFG_SYMBOL_OFFSET = 2'd1
    } cfg_index_t;

    localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RESET    = 6'd32;
    localparam logic [SYM_W-1:0]    SYMBOL_OFFSET_RESET = 16'd0;

endpackage

@@ sv/cca_stream_if.sv @@
// Interfaces: length input channel and codeword result channel.
`timescale 1ns / 1ps

interface cca_len_if;
    logic                             valid;
    logic                             ready;
    logic signed [cca_pkg::LEN_W-1:0] code_length;
    logic        [cca_pkg::SYM_W-1:0] symbol;
    logic                             last_entry;

    modport source (output valid, output code_length, output symbol, output last_entry,
                    input ready);
    modport sink   (input valid, input code_length, input symbol, input last_entry,
                    output ready);
endinterface

interface cca_code_if;
    logic                                       valid;
    logic                                       ready;
    logic [cca_pkg::CODE_SPACE_BITS-1:0]        codeword;
    logic [cca_pkg::LEN_OUT_W-1:0]              length_out;
    logic [cca_pkg::SYM_W-1:0]                  symbol_out;
    cca_pkg::status_t                           status;
    logic                                       last_out;

    modport source (output valid, output codeword, output length_out, output symbol_out,
                    output status, output last_out, input ready);
    modport sink   (input valid, input codeword, input length_out, input symbol_out,
                    input status, input last_out, output ready);
endinterface

@@ sv/canonical_code_assigner_unit.sv @@
// Canonical code assigner: input register, one accumulator step, result register.
// Throughput: one length per cycle while the result channel is not stalled.
// A stalled result holds the output register; the input register takes one more
// length and then stalls the input. Reset (rst_n low, asynchronous) clears the
// accumulator, the sticky error and both valid flags, and sets the config registers to defaults.
`timescale 1ns / 1ps

module canonical_code_assigner_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cca_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cca_pkg::CFG_DATA_W-1:0]      cfg_data,
    cca_len_if.sink                             len_ch,
    cca_code_if.source                          code_ch
);

    localparam int CW  = cca_pkg::CODE_SPACE_BITS;
    localparam int ACW = CW + 1;
    localparam int SHW = $clog2(CW);

    logic [cca_pkg::MAXLEN_W-1:0]   max_length_reg;
    logic [cca_pkg::SYM_W-1:0]      symbol_offset_reg;
    logic [ACW-1:0]                 next_code_reg, next_code_next;
    logic                           error_seen_reg, error_seen_next;

    logic                           s1_valid_reg;
    logic [cca_pkg::LEN_W-1:0]      s1_length_reg;
    logic [cca_pkg::SYM_W-1:0]      s1_symbol_reg;
    logic                           s1_last_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [CW-1:0]                  codeword_reg;
    logic [cca_pkg::LEN_OUT_W-1:0]  length_out_reg;
    logic [cca_pkg::SYM_W-1:0]      symbol_out_reg;
    cca_pkg::status_t               status_reg;
    logic                           last_out_reg;

    logic                           out_free, s1_fire, in_fire;
    logic                           negative;
    logic [cca_pkg::LEN_W-1:0]      abs_len;
    logic [cca_pkg::MAXLEN_W-1:0]   limit;
    logic                           too_long;
    logic [SHW-1:0]                 shift;
    logic [ACW-1:0]                 step;
    logic [ACW:0]                   sum;
    logic                           misaligned, overfull;
    cca_pkg::status_t               status;
    logic                           emit;
    logic [CW-1:0]                  codeword;

    assign out_free     = !out_valid_reg || code_ch.ready;
    assign s1_fire      = s1_valid_reg && out_free;
    assign len_ch.ready = !s1_valid_reg || out_free;
    assign in_fire      = len_ch.valid && len_ch.ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg    <= cca_pkg::MAX_LENGTH_RESET;
            symbol_offset_reg <= cca_pkg::SYMBOL_OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cca_pkg::CFG_MAX_LENGTH:
                    max_length_reg <= cfg_data[cca_pkg::MAXLEN_W-1:0];
                cca_pkg::CFG_SYMBOL_OFFSET:
                    symbol_offset_reg <= cfg_data[cca_pkg::SYM_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (len_ch.ready)
        begin
            s1_valid_reg <= len_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_length_reg <= len_ch.code_length;
            s1_symbol_reg <= len_ch.symbol;
            s1_last_reg   <= len_ch.last_entry;
        end
    end

    // accumulator step
    always_comb
    begin
        negative   = s1_length_reg[cca_pkg::LEN_W-1];
        abs_len    = negative ? (~s1_length_reg + 1'b1) : s1_length_reg;
        limit      = (max_length_reg > cca_pkg::MAXLEN_W'(CW)) ?
                     cca_pkg::MAXLEN_W'(CW) : max_length_reg;
        too_long   = abs_len > {2'b00, limit};
        shift      = SHW'(cca_pkg::MAXLEN_W'(CW) - abs_len[cca_pkg::MAXLEN_W-1:0]);
        step       = ACW'(1) << shift;
        misaligned = |(next_code_reg & (step - 1'b1));
        sum        = {1'b0, next_code_reg} + {1'b0, step};
        overfull   = sum > (ACW+1)'(ACW'(1) << CW);
        codeword   = CW'(next_code_reg >> shift);

        status          = cca_pkg::STATUS_OK;
        emit            = 1'b0;
        next_code_next  = next_code_reg;
        error_seen_next = error_seen_reg;

        if (abs_len != '0)
        begin
            if (error_seen_reg)
            begin
                status = cca_pkg::STATUS_PRIOR_ERROR;
                emit   = !negative;
            end
            else if (too_long || misaligned)
            begin
                status          = cca_pkg::STATUS_BAD_LENGTH;
                emit            = 1'b1;
                error_seen_next = 1'b1;
            end
            else if (overfull)
            begin
                status          = cca_pkg::STATUS_OVERFULL;
                emit            = 1'b1;
                error_seen_next = 1'b1;
            end
            else
            begin
                emit           = !negative;
                next_code_next = sum[ACW-1:0];
            end
        end

        if (s1_last_reg)
        begin
            next_code_next  = '0;
            error_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_code_reg  <= '0;
            error_seen_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            next_code_reg  <= next_code_next;
            error_seen_reg <= error_seen_next;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !code_ch.ready;
        if (s1_fire)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
        begin
            codeword_reg   <= (status == cca_pkg::STATUS_OK) ? codeword : '0;
            length_out_reg <= abs_len[cca_pkg::LEN_W-1] ?
                              {cca_pkg::LEN_OUT_W{1'b1}} : abs_len[cca_pkg::LEN_OUT_W-1:0];
            symbol_out_reg <= s1_symbol_reg + symbol_offset_reg;
            status_reg     <= status;
            last_out_reg   <= s1_last_reg;
        end
    end

    assign code_ch.valid      = out_valid_reg;
    assign code_ch.codeword   = codeword_reg;
    assign code_ch.length_out = length_out_reg;
    assign code_ch.symbol_out = symbol_out_reg;
    assign code_ch.status     = status_reg;
    assign code_ch.last_out   = last_out_reg;

    // checks
    a_code_space_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_code_reg[CW] |-> (next_code_reg[CW-1:0] == '0))
        else $error("accumulator beyond full code space");

    a_end_of_table_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (next_code_reg == '0 && !error_seen_reg))
        else $error("state not cleared after last entry");

    a_codeword_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == cca_pkg::STATUS_OK) |->
        ((ACW'(codeword_reg) >> length_out_reg) == '0))
        else $error("codeword wider than its length");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        !len_ch.ready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room downstream");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for canonical_code_assigner_unit: directed and random length tables.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 210;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [33:0] SPACE_FULL = 34'h1_0000_0000;

    typedef struct {
        logic signed [cca_pkg::LEN_W-1:0] clen;
        logic [cca_pkg::SYM_W-1:0]        sym;
        logic                             last;
    } length_item_t;

    typedef struct {
        logic [cca_pkg::CODE_SPACE_BITS-1:0] codeword;
        logic [cca_pkg::LEN_OUT_W-1:0]       length_out;
        logic [cca_pkg::SYM_W-1:0]           symbol_out;
        cca_pkg::status_t                    status;
        logic                                last;
    } code_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [cca_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cca_pkg::CFG_DATA_W-1:0] cfg_data;

    cca_len_if  len_ch();
    cca_code_if code_ch();

    canonical_code_assigner_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .len_ch    (len_ch),
        .code_ch   (code_ch)
    );

    // predictor state and register copies
    logic [cca_pkg::MAXLEN_W-1:0] max_length_q;
    logic [cca_pkg::SYM_W-1:0]    offset_q;
    logic [32:0]                  next_code_q;
    bit                           error_seen_q;

    length_item_t length_queue[$];
    code_result_t expected_codes[$];

    int send_idle;
    int recv_idle;
    bit hold_trigger;
    bit hold_seen;
    int hold_left;
    int fail_count;
    int sent_count;
    int checked_count;
    int error_results;
    int settings_count;
    int cycle_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit assign_code(input length_item_t it, output code_result_t res);
        logic [7:0]  mag;
        logic [32:0] stride;
        logic [32:0] shifted;
        int          limit;
        int          shift;
        bit          neg;
        neg = it.clen[7];
        mag = neg ? 8'd0 - it.clen : it.clen;
        limit = (max_length_q < 32) ? int'(max_length_q) : 32;
        res.codeword = '0;
        res.length_out = (mag > 8'd127) ? 7'd127 : mag[6:0];
        res.symbol_out = it.sym + offset_q;
        res.status = cca_pkg::STATUS_OK;
        res.last = it.last;
        assign_code = 1'b0;
        if (mag != 8'd0 && !(error_seen_q && neg))
        begin
            if (error_seen_q)
                res.status = cca_pkg::STATUS_PRIOR_ERROR;
            else if (int'(mag) > limit)
                res.status = cca_pkg::STATUS_BAD_LENGTH;
            else
            begin
                shift = cca_pkg::CODE_SPACE_BITS - int'(mag);
                stride = 33'd1 << shift;
                if ((next_code_q & (stride - 33'd1)) != 33'd0)
                    res.status = cca_pkg::STATUS_BAD_LENGTH;
                else if ({1'b0, next_code_q} + {1'b0, stride} > SPACE_FULL)
                    res.status = cca_pkg::STATUS_OVERFULL;
                else
                begin
                    shifted = next_code_q >> shift;
                    res.codeword = shifted[31:0];
                    next_code_q = next_code_q + stride;
                end
            end
            if (res.status == cca_pkg::STATUS_BAD_LENGTH ||
                res.status == cca_pkg::STATUS_OVERFULL)
                error_seen_q = 1'b1;
            assign_code = !(neg && res.status == cca_pkg::STATUS_OK);
        end
        if (it.last)
        begin
            next_code_q = '0;
            error_seen_q = 1'b0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : driver
        length_item_t it;
        if (!rst_n)
            len_ch.valid <= 1'b0;
        else if (!len_ch.valid || len_ch.ready)
        begin
            if (length_queue.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                it = length_queue.pop_front();
                len_ch.valid       <= 1'b1;
                len_ch.code_length <= it.clen;
                len_ch.symbol      <= it.sym;
                len_ch.last_entry  <= it.last;
            end
            else
                len_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : receiver
        if (!rst_n)
            code_ch.ready <= 1'b0;
        else if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            code_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            code_ch.ready <= 1'b0;
        end
        else
            code_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin : monitor
        code_result_t want;
        length_item_t taken;
        if (rst_n)
        begin
            if (code_ch.valid && code_ch.ready)
            begin
                if (expected_codes.size() == 0)
                begin
                    $error("unexpected result transaction: codeword %0h symbol %0h status %0d",
                           code_ch.codeword, code_ch.symbol_out, code_ch.status);
                    fail_count++;
                end
                else
                begin
                    want = expected_codes.pop_front();
                    checked_count++;
                    if (code_ch.status != cca_pkg::STATUS_OK)
                        error_results++;
                    check_field("codeword", want.codeword, code_ch.codeword);
                    check_field("length_out", 32'(want.length_out), 32'(code_ch.length_out));
                    check_field("symbol_out", 32'(want.symbol_out), 32'(code_ch.symbol_out));
                    check_field("status", 32'(want.status), 32'(code_ch.status));
                    check_field("last_out", 32'(want.last), 32'(code_ch.last_out));
                end
            end
            if (len_ch.valid && len_ch.ready)
            begin
                taken.clen = len_ch.code_length;
                taken.sym  = len_ch.symbol;
                taken.last = len_ch.last_entry;
                sent_count++;
                if (assign_code(taken, want))
                    expected_codes.push_back(want);
            end
        end
    end

    task automatic write_reg(input cca_pkg::cfg_index_t idx,
                             input logic [cca_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == cca_pkg::CFG_MAX_LENGTH)
            max_length_q = value[cca_pkg::MAXLEN_W-1:0];
        else
            offset_q = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (length_queue.size() != 0 || len_ch.valid || expected_codes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_length(input int clen, input int sym, input bit last);
        length_item_t it;
        it.clen = cca_pkg::LEN_W'(clen);
        it.sym  = cca_pkg::SYM_W'(sym);
        it.last = last;
        length_queue.push_back(it);
    endtask

    // builds a complete prefix code by leaf splitting, then optionally breaks it
    task automatic queue_table(output int nonzero);
        int depths[$];
        int gen_lim;
        int splits;
        int idx;
        int d;
        bit zero_close;
        gen_lim = (max_length_q == 0) ? 1 : ((max_length_q > 32) ? 32 : int'(max_length_q));
        depths.push_back(0);
        if ($urandom_range(3) == 0)
        begin
            splits = $urandom_range(gen_lim, 1);
            repeat (splits)
            begin
                idx = 0;
                foreach (depths[i])
                    if (depths[i] > depths[idx])
                        idx = i;
                d = depths[idx];
                depths.delete(idx);
                depths.push_back(d + 1);
                depths.push_back(d + 1);
            end
        end
        else
        begin
            splits = $urandom_range(12, 1);
            repeat (splits)
            begin
                idx = $urandom_range(depths.size() - 1);
                if (depths[idx] < gen_lim)
                begin
                    d = depths[idx];
                    depths.delete(idx);
                    depths.push_back(d + 1);
                    depths.push_back(d + 1);
                end
            end
        end
        depths.sort();
        case ($urandom_range(9))
            0: if (depths.size() > 1) depths.delete($urandom_range(depths.size() - 1));
            1: depths.push_back($urandom_range(gen_lim, 1));
            2:
            begin
                idx = $urandom_range(depths.size() - 1);
                d = depths[idx];
                depths[idx] = depths[0];
                depths[0] = d;
            end
            3: depths[$urandom_range(depths.size() - 1)] = $urandom_range(128, gen_lim + 1);
            default: ;
        endcase
        zero_close = ($urandom_range(9) == 0);
        nonzero = 0;
        foreach (depths[i])
        begin
            if ($urandom_range(9) == 0)
                add_length(0, $urandom_range(16'hFFFF), 1'b0);
            add_length(($urandom_range(4) == 0) ? -depths[i] : depths[i],
                       $urandom_range(16'hFFFF),
                       (i == depths.size() - 1) && !zero_close);
            nonzero++;
        end
        if (zero_close)
            add_length(0, $urandom_range(16'hFFFF), 1'b1);
    endtask

    task automatic run_phase(input logic [cca_pkg::MAXLEN_W-1:0] maxlen,
                             input logic [cca_pkg::SYM_W-1:0] offset,
                             input int sidle, input int ridle, input bit hold);
        int queued;
        int n;
        write_reg(cca_pkg::CFG_MAX_LENGTH, cca_pkg::CFG_DATA_W'(maxlen));
        write_reg(cca_pkg::CFG_SYMBOL_OFFSET, offset);
        settings_count++;
        send_idle = sidle;
        recv_idle = ridle;
        queued = 0;
        while (queued < PHASE_ITEMS)
        begin
            if ($urandom_range(6) != 0)
            begin
                queue_table(n);
                queued += n;
            end
            else
            begin
                repeat ($urandom_range(5, 1))
                begin
                    add_length($urandom_range(255), $urandom_range(16'hFFFF),
                               $urandom_range(9) == 0);
                    queued++;
                end
            end
        end
        if (hold)
        begin
            @(negedge clk);
            hold_trigger = !hold_trigger;
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = cca_pkg::CFG_MAX_LENGTH;
        cfg_data = '0;
        len_ch.valid = 1'b0;
        len_ch.code_length = '0;
        len_ch.symbol = '0;
        len_ch.last_entry = 1'b0;
        code_ch.ready = 1'b0;
        max_length_q = cca_pkg::MAX_LENGTH_RESET;
        offset_q = cca_pkg::SYMBOL_OFFSET_RESET;
        next_code_q = '0;
        error_seen_q = 1'b0;
        send_idle = 30;
        recv_idle = 65;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed table walk at the reset settings
        write_reg(cca_pkg::CFG_MAX_LENGTH, 16'd32);
        write_reg(cca_pkg::CFG_SYMBOL_OFFSET, 16'd0);
        settings_count++;
        add_length(1, 16'h0000, 1'b0);
        add_length(-1, 16'hFFFF, 1'b0);
        add_length(5, 16'h1234, 1'b1);
        add_length(0, 16'h5555, 1'b0);
        add_length(127, 16'hAAAA, 1'b0);
        add_length(3, 16'h0001, 1'b0);
        add_length(-3, 16'h0002, 1'b0);
        add_length(0, 16'h0003, 1'b1);
        add_length(-128, 16'h8000, 1'b1);
        add_length(2, 16'h0004, 1'b0);
        add_length(1, 16'h0005, 1'b0);
        add_length(1, 16'h0006, 1'b1);
        add_length(32, 16'h0007, 1'b0);
        add_length(32, 16'h0008, 1'b0);
        add_length(-31, 16'h0009, 1'b0);
        add_length(31, 16'h000A, 1'b0);
        add_length(-33, 16'h000B, 1'b1);
        add_length(-1, 16'hFFFF, 1'b0);
        add_length(1, 16'hFFFF, 1'b1);
        add_length(-127, 16'h0000, 1'b1);
        wait_drained();

        run_phase(6'd32, 16'h7FFF, 30, 65, 1'b0);
        run_phase(6'd1, 16'h8000, 30, 65, 1'b0);
        run_phase(6'd0, cca_pkg::SYM_W'($urandom_range(16'hFFFF)), 30, 65, 1'b0);
        run_phase(6'd20, cca_pkg::SYM_W'($urandom_range(16'hFFFF)), 65, 30, 1'b0);
        run_phase(6'd63, 16'hFFFF, 65, 30, 1'b0);
        run_phase(6'd8, cca_pkg::SYM_W'($urandom_range(16'hFFFF)), 65, 30, 1'b0);
        run_phase(6'd32, 16'h0000, 0, 0, 1'b1);
        run_phase(cca_pkg::MAXLEN_W'($urandom_range(32, 1)),
                  cca_pkg::SYM_W'($urandom_range(16'hFFFF)), 0, 0, 1'b0);

        $display("Run covered %0d length transactions and %0d codeword results",
                 sent_count, checked_count);
        $display("(%0d with error status) across %0d register settings in %0d cycles.",
                 error_results, settings_count, cycle_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
